// ===== hdl/bci_pkg.sv =====
// Shared widths, command codes and beat types of the breakpoint curve interpolator.
`default_nettype none

package bci_pkg;

    localparam int KEY_W     = 32;
    localparam int X_W       = 16;
    localparam int VALUE_W   = 16;
    localparam int CNT_W     = 4;
    localparam int SLOT_W    = 4;
    localparam int PIDX_W    = 3;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 5;
    localparam int NUM_VALS  = 3;

    localparam int DEF_CURVES = 16;
    localparam int DEF_POINTS = 8;

    localparam logic [CMD_W-1:0] CMD_HEADER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POINT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

    // Command beat.
    typedef struct packed {
        logic        [CMD_W-1:0]   cmd;
        logic        [SLOT_W-1:0]  curve_slot;
        logic        [PIDX_W-1:0]  point_index;
        logic        [KEY_W-1:0]   curve_key;
        logic        [CNT_W-1:0]   point_count;
        logic        [X_W-1:0]     x_value;
        logic signed [VALUE_W-1:0] y_first;
        logic signed [VALUE_W-1:0] y_second;
        logic signed [VALUE_W-1:0] y_third;
    } bci_cmd_t;

    // Result beat.
    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] out_first;
        logic signed [VALUE_W-1:0] out_second;
        logic signed [VALUE_W-1:0] out_third;
    } bci_res_t;

    // Three curve values; element 0 is the first value.
    typedef logic [NUM_VALS-1:0][VALUE_W-1:0] bci_vals_t;

    // One breakpoint word in the point memory.
    typedef struct packed {
        logic [X_W-1:0] x;
        bci_vals_t      y;
    } bci_point_t;

    // One curve header word in the key memory.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } bci_key_t;

endpackage

`default_nettype wire

// ===== hdl/bci_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/bci_div.sv =====
// Restoring serial divider that forms the segment ratio, one quotient bit per cycle.
`default_nettype none

module bci_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [bci_pkg::X_W-1:0] num,
    input  logic [bci_pkg::X_W-1:0] den,
    output logic                   done,
    output logic [bci_pkg::X_W:0]   quot
);

    import bci_pkg::*;

    // num <= den, so the quotient of (num << X_W) / den has X_W + 1 bits.
    localparam int STEPS = X_W + 1;
    localparam int SCW   = $clog2(STEPS + 1);

    logic [SCW-1:0] step_reg, step_next;
    logic           done_reg, done_next;
    logic [X_W:0]   rem_reg, rem_next;
    logic [X_W-1:0] den_reg, den_next;
    logic [X_W:0]   quot_reg, quot_next;
    logic           zero_reg, zero_next;

    logic           ge;
    logic [X_W:0]   trial;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, den_reg};
        trial     = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        zero_next = zero_reg;
        if (start)
        begin
            step_next = SCW'(STEPS);
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            zero_next = (den == '0);
        end
        else if (step_reg != '0)
        begin
            // Subtract where it fits, then shift in the next zero bit.
            quot_next = {quot_reg[X_W-1:0], ge};
            rem_next  = {trial[X_W-1:0], 1'b0};
            step_next = step_reg - SCW'(1);
            done_next = (step_reg == SCW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        zero_reg <= zero_next;
    end

    // A zero-width segment gets ratio zero.
    assign done = done_reg;
    assign quot = zero_reg ? '0 : quot_reg;

endmodule

`default_nettype wire

// ===== hdl/bci_lerp.sv =====
// Shared multiplier that blends the three curve values one after another.
`default_nettype none

module bci_lerp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [bci_pkg::X_W:0] ratio,
    input  bci_pkg::bci_vals_t  ya,
    input  bci_pkg::bci_vals_t  yb,
    output logic                done,
    output bci_pkg::bci_vals_t  y
);

    import bci_pkg::*;

    localparam int PW   = VALUE_W + X_W + 3;
    localparam int LCW  = $clog2(NUM_VALS + 1);
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (X_W - 1);

    logic [LCW-1:0]            lane_reg, lane_next;
    logic                      acc_valid_reg, acc_valid_next;
    logic                      acc_last_reg, acc_last_next;
    logic                      done_reg, done_next;
    bci_vals_t                 ya_reg, ya_next;
    bci_vals_t                 yb_reg, yb_next;
    bci_vals_t                 y_reg, y_next;
    logic [X_W:0]              ratio_reg, ratio_next;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic [VALUE_W-1:0]        base_reg, base_next;

    logic signed [VALUE_W:0]   diff;
    logic signed [PW-1:0]      rounded;
    logic signed [PW-1:0]      scaled;
    logic [VALUE_W-1:0]        blended;

    always_comb
    begin
        diff = $signed({yb_reg[0][VALUE_W-1], yb_reg[0]})
             - $signed({ya_reg[0][VALUE_W-1], ya_reg[0]});
        rounded = prod_reg + HALF;
        scaled  = rounded >>> X_W;
        blended = base_reg + scaled[VALUE_W-1:0];

        lane_next      = lane_reg;
        acc_valid_next = 1'b0;
        acc_last_next  = 1'b0;
        done_next      = 1'b0;
        ya_next        = ya_reg;
        yb_next        = yb_reg;
        y_next         = y_reg;
        ratio_next     = ratio_reg;
        prod_next      = prod_reg;
        base_next      = base_reg;

        if (start)
        begin
            lane_next  = LCW'(NUM_VALS);
            ya_next    = ya;
            yb_next    = yb;
            ratio_next = ratio;
        end
        else if (lane_reg != '0)
        begin
            // Multiply lane 0, then rotate the next value into place.
            prod_next      = PW'(diff) * PW'($signed({1'b0, ratio_reg}));
            base_next      = ya_reg[0];
            ya_next        = {ya_reg[0], ya_reg[NUM_VALS-1:1]};
            yb_next        = {yb_reg[0], yb_reg[NUM_VALS-1:1]};
            lane_next      = lane_reg - LCW'(1);
            acc_valid_next = 1'b1;
            acc_last_next  = (lane_reg == LCW'(1));
        end

        if (acc_valid_reg)
        begin
            // Round half up, then shift results down so the first lands at 0.
            y_next    = {blended, y_reg[NUM_VALS-1:1]};
            done_next = acc_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg      <= '0;
            acc_valid_reg <= 1'b0;
            acc_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            lane_reg      <= lane_next;
            acc_valid_reg <= acc_valid_next;
            acc_last_reg  <= acc_last_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ya_reg    <= ya_next;
        yb_reg    <= yb_next;
        y_reg     <= y_next;
        ratio_reg <= ratio_next;
        prod_reg  <= prod_next;
        base_reg  <= base_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

`default_nettype wire

// ===== hdl/breakpoint_curve_interpolator.sv =====
// Top level: curve store, key scan and breakpoint search sequencer, result register.
//
//   beat        signals                      width            direction
//   ----------  ---------------------------  ---------------  ---------
//   command     cmd_valid / cmd_stall        bci_cmd_t        in
//   result      res_valid / res_stall        bci_res_t        out
//   config      cfg_write, cfg_wdata         5 (curves_in_use) in
//
// Header and breakpoint writes go straight to the RAMs; cmd_stall stays low, so writes
// may stream back to back. An evaluate holds cmd_stall high until its result has
// been loaded into the result register. The stall covers the key scan (one slot per
// cycle from the key RAM), the segment scan (one breakpoint per cycle from the point
// RAM), the serial divider, and the one shared multiplier that blends the three
// values in turn; a clamp to the first or last point or a miss skips the later steps.
// Reset clears the sequencer, the curve valid bits, curves_in_use and the result valid
// flag; the RAMs are not cleared, a slot reads as empty until its header is written.
// A finished result waits in the result register while res_stall is high; the next
// command is taken meanwhile and only the end of a following evaluate holds.
`default_nettype none

module breakpoint_curve_interpolator #(
    parameter int CURVES = bci_pkg::DEF_CURVES,
    parameter int POINTS = bci_pkg::DEF_POINTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  bci_pkg::bci_cmd_t           cmd_beat,
    output logic                        res_valid,
    input  logic                        res_stall,
    output bci_pkg::bci_res_t           res_beat,
    input  logic                        cfg_write,
    input  logic [bci_pkg::CFG_W-1:0]   cfg_wdata
);

    import bci_pkg::*;

    localparam int SW      = (CURVES > 1) ? $clog2(CURVES) : 1;
    localparam int ENTRIES = CURVES * POINTS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW      = ($clog2(CURVES + 1) > CFG_W) ? $clog2(CURVES + 1) : CFG_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_KEY   = 8'b0000_0010,
        ST_FIRST = 8'b0000_0100,
        ST_LAST  = 8'b0000_1000,
        ST_LOOP  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_LERP  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // Control state.
    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg, cfg_next;
    logic [CURVES-1:0]    valid_reg, valid_next;
    logic                 res_valid_reg, res_valid_next;

    // Evaluate working registers.
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [X_W-1:0]       x_reg, x_next;
    logic [LW-1:0]        limit_reg, limit_next;
    logic [SW-1:0]        scan_reg, scan_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    bci_point_t           word0_reg, word0_next;
    bci_point_t           a_reg, a_next;
    bci_point_t           b_reg, b_next;
    logic                 fin_found_reg, fin_found_next;
    bci_vals_t            fin_vals_reg, fin_vals_next;
    bci_res_t             res_beat_reg, res_beat_next;

    // Command decode.
    logic                 cmd_accept;
    logic [8:0]           slot_ext;
    logic                 slot_ok;
    logic                 pidx_ok;
    logic [15:0]          pt_waddr_full;
    logic [LW-1:0]        cfg_ext;
    logic [LW-1:0]        limit_w;
    logic [CNT_W-1:0]     count_sat;

    // Memories.
    logic                 key_we;
    logic [SW-1:0]        key_waddr;
    bci_key_t             key_wdata;
    bci_key_t             key_rdata;
    logic                 pt_we;
    logic [AW-1:0]        pt_waddr;
    bci_point_t           pt_wdata;
    logic [AW-1:0]        pt_raddr;
    bci_point_t           pt_rdata;

    // Arithmetic units.
    logic                 div_start;
    logic                 div_done;
    logic [X_W:0]         div_quot;
    logic                 lerp_start;
    logic                 lerp_done;
    bci_vals_t            lerp_y;

    logic                 key_hit;
    logic                 scan_more;
    logic                 in_segment;
    logic                 loop_more;
    logic                 out_free;

    // ---------------------------------------------------------------------
    // Command decode: writes go straight to the RAMs in the accept cycle.
    // ---------------------------------------------------------------------
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign slot_ext      = 9'(cmd_beat.curve_slot);
    assign slot_ok       = slot_ext < 9'(CURVES);
    assign pidx_ok       = 7'(cmd_beat.point_index) < 7'(POINTS);
    assign pt_waddr_full = 16'(slot_ext) * 16'(POINTS) + 16'(cmd_beat.point_index);

    // Clamp the point count to the curve's capacity.
    assign count_sat = (8'(cmd_beat.point_count) > 8'(POINTS)) ? CNT_W'(POINTS)
                                                               : cmd_beat.point_count;

    // Clamp the number of searched slots to the store size.
    assign cfg_ext = LW'(cfg_reg);
    assign limit_w = (cfg_ext > LW'(CURVES)) ? LW'(CURVES) : cfg_ext;

    assign key_we    = cmd_accept && (cmd_beat.cmd == CMD_HEADER) && slot_ok;
    assign key_waddr = slot_ext[SW-1:0];
    assign key_wdata = '{key: cmd_beat.curve_key, count: count_sat};

    assign pt_we    = cmd_accept && (cmd_beat.cmd == CMD_POINT) && slot_ok && pidx_ok;
    assign pt_waddr = pt_waddr_full[AW-1:0];
    assign pt_wdata = '{x: cmd_beat.x_value,
                        y: {cmd_beat.y_third, cmd_beat.y_second, cmd_beat.y_first}};

    // ---------------------------------------------------------------------
    // Storage: key RAM read address follows the next scan slot, so the word
    // for scan_reg is always on key_rdata in the key-check state.
    // ---------------------------------------------------------------------
    bci_ram #(
        .WIDTH ($bits(bci_key_t)),
        .DEPTH (CURVES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (scan_next),
        .rdata (key_rdata)
    );

    bci_ram #(
        .WIDTH ($bits(bci_point_t)),
        .DEPTH (ENTRIES)
    ) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    bci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (x_reg - a_reg.x),
        .den   (pt_rdata.x - a_reg.x),
        .done  (div_done),
        .quot  (div_quot)
    );

    bci_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .ratio (div_quot),
        .ya    (a_reg.y),
        .yb    (b_reg.y),
        .done  (lerp_done),
        .y     (lerp_y)
    );

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    assign key_hit    = valid_reg[scan_reg] && (key_rdata.key == key_reg)
                        && (key_rdata.count != '0);
    assign scan_more  = (LW'(scan_reg) + LW'(1)) < limit_reg;
    assign in_segment = (x_reg >= a_reg.x) && (x_reg <= pt_rdata.x);
    assign loop_more  = ((5'(idx_reg) + 5'd2) < 5'(cnt_reg));
    assign out_free   = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_write ? cfg_wdata : cfg_reg;
        valid_next     = valid_reg;
        key_next       = key_reg;
        x_next         = x_reg;
        limit_next     = limit_reg;
        scan_next      = scan_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        word0_next     = word0_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        fin_found_next = fin_found_reg;
        fin_vals_next  = fin_vals_reg;
        res_beat_next  = res_beat_reg;
        res_valid_next = res_valid_reg && res_stall;
        pt_raddr       = base_reg;
        div_start      = 1'b0;
        lerp_start     = 1'b0;

        if (key_we)
        begin
            valid_next[key_waddr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept && (cmd_beat.cmd == CMD_EVAL))
                begin
                    key_next   = cmd_beat.curve_key;
                    x_next     = cmd_beat.x_value;
                    limit_next = limit_w;
                    scan_next  = '0;
                    base_next  = '0;
                    if (limit_w == '0)
                    begin
                        fin_found_next = 1'b0;
                        fin_vals_next  = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_KEY;
                    end
                end
            end

            ST_KEY:
            begin
                // One slot per cycle; fetch the first breakpoint on a hit.
                if (key_hit)
                begin
                    cnt_next   = key_rdata.count;
                    pt_raddr   = base_reg;
                    state_next = ST_FIRST;
                end
                else if (scan_more)
                begin
                    scan_next = scan_reg + SW'(1);
                    base_next = base_reg + AW'(POINTS);
                end
                else
                begin
                    fin_found_next = 1'b0;
                    fin_vals_next  = '0;
                    state_next     = ST_DONE;
                end
            end

            ST_FIRST:
            begin
                // Clamp below the first x, otherwise fetch the last breakpoint.
                word0_next = pt_rdata;
                if (x_reg <= pt_rdata.x)
                begin
                    fin_found_next = 1'b1;
                    fin_vals_next  = pt_rdata.y;
                    state_next     = ST_DONE;
                end
                else
                begin
                    pt_raddr   = base_reg + AW'(cnt_reg - CNT_W'(1));
                    state_next = ST_LAST;
                end
            end

            ST_LAST:
            begin
                // Clamp above the last x, otherwise walk the segments.
                if (x_reg >= pt_rdata.x)
                begin
                    fin_found_next = 1'b1;
                    fin_vals_next  = pt_rdata.y;
                    state_next     = ST_DONE;
                end
                else
                begin
                    a_next     = word0_reg;
                    idx_next   = '0;
                    pt_raddr   = base_reg + AW'(1);
                    state_next = ST_LOOP;
                end
            end

            ST_LOOP:
            begin
                // a_reg holds the segment start, pt_rdata its end.
                if (in_segment)
                begin
                    b_next     = pt_rdata;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    a_next   = pt_rdata;
                    idx_next = idx_reg + CNT_W'(1);
                    if (loop_more)
                    begin
                        pt_raddr = base_reg + AW'(idx_reg + CNT_W'(2));
                    end
                    else
                    begin
                        // No segment holds x: fall back to the first breakpoint.
                        fin_found_next = 1'b1;
                        fin_vals_next  = word0_reg.y;
                        state_next     = ST_DONE;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    lerp_start = 1'b1;
                    state_next = ST_LERP;
                end
            end

            ST_LERP:
            begin
                if (lerp_done)
                begin
                    fin_found_next = 1'b1;
                    fin_vals_next  = lerp_y;
                    state_next     = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the result register is free.
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_beat_next  = '{found:      fin_found_reg,
                                       out_first:  fin_vals_reg[0],
                                       out_second: fin_vals_reg[1],
                                       out_third:  fin_vals_reg[2]};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= '0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        x_reg         <= x_next;
        limit_reg     <= limit_next;
        scan_reg      <= scan_next;
        base_reg      <= base_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        word0_reg     <= word0_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        fin_found_reg <= fin_found_next;
        fin_vals_reg  <= fin_vals_next;
        res_beat_reg  <= res_beat_next;
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

endmodule

`default_nettype wire
